// ----- src/mmh_pkg.sv -----
// ----------------------------------------------------------------------------
// mmh_pkg: shared types and constants of the MurmurHash3 stream hasher
// Mixing constants, the queue entry layout and the back-end sequencer states.
// ----------------------------------------------------------------------------
package mmh_pkg;

	// Key scramble and hash update constants.
	localparam logic [31:0] C1    = 32'hcc9e2d51;
	localparam logic [31:0] C2    = 32'h1b873593;
	localparam logic [31:0] ADD_N = 32'he6546b64;

	// Finalization mix constants.
	localparam logic [31:0] FMIX1 = 32'h85ebca6b;
	localparam logic [31:0] FMIX2 = 32'hc2b2ae35;

	// Bytes in a full word.
	localparam logic [2:0] FULL_COUNT = 3'd4;

	// Depth of the queue between front and back, and its pointer width.
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// One classified item as it travels from front to back.
	typedef struct packed {
		logic [31:0] word;   // data word with unused bytes cleared
		logic [2:0]  count;  // saturated byte count, 4 on non-last items
		logic        last;   // final item of the message
	} entry_t;

	// Back-end sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCRAMBLE,
		ST_FOLD,
		ST_FMIX1,
		ST_FMIX2,
		ST_OUT
	} back_state_t;

endpackage

// ----- src/mmh_in_if.sv -----
// ----------------------------------------------------------------------------
// mmh_in_if: message word channel
// Valid/ready channel carrying one message word with its byte count and end mark.
// ----------------------------------------------------------------------------
interface mmh_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        is_last;

	modport source (output valid, data_word, byte_count, is_last, input ready);
	modport sink (input valid, data_word, byte_count, is_last, output ready);
endinterface

// ----- src/mmh_out_if.sv -----
// ----------------------------------------------------------------------------
// mmh_out_if: hash result channel
// Valid/ready channel carrying one finished 32-bit hash.
// ----------------------------------------------------------------------------
interface mmh_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

// ----- src/mmh_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mmh_cfg_if: seed register write channel
// Valid/ready channel carrying the write data of the seed register.
// ----------------------------------------------------------------------------
interface mmh_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] seed;

	modport source (output valid, seed, input ready);
	modport sink (input valid, seed, output ready);
endinterface

// ----- src/mmh_front.sv -----
// ----------------------------------------------------------------------------
// mmh_front: input classifier
// Takes message words, saturates the byte count, clears unused bytes and
// hands a queue entry to the back end.
// ----------------------------------------------------------------------------
module mmh_front
	import mmh_pkg::*;
(
	mmh_in_if.sink     msg_in,
	input  logic       q_full,
	output logic       push,
	output entry_t     push_entry
);

	logic [2:0]  count_sat;
	logic [31:0] mask;

	// A non-last item always counts as a full word; oversized counts clamp to four.
	always_comb begin
		if (!msg_in.is_last || msg_in.byte_count > FULL_COUNT) begin
			count_sat = FULL_COUNT;
		end else begin
			count_sat = msg_in.byte_count;
		end
	end

	// Keep only the valid low bytes of the word.
	always_comb begin
		case (count_sat)
			3'd0:    mask = 32'h0000_0000;
			3'd1:    mask = 32'h0000_00ff;
			3'd2:    mask = 32'h0000_ffff;
			3'd3:    mask = 32'h00ff_ffff;
			default: mask = 32'hffff_ffff;
		endcase
	end

	// The word channel is ready whenever the queue has room.
	assign msg_in.ready     = !q_full;
	assign push             = msg_in.valid && !q_full;
	assign push_entry.word  = msg_in.data_word & mask;
	assign push_entry.count = count_sat;
	assign push_entry.last  = msg_in.is_last;

endmodule

// ----- src/mmh_queue.sv -----
// ----------------------------------------------------------------------------
// mmh_queue: short FIFO between front and back
// Holds classified entries so that either side can stall on its own.
// ----------------------------------------------------------------------------
module mmh_queue
	import mmh_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output logic   full,
	output logic   not_empty,
	output entry_t head
);

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   fill_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign full      = (fill_q == (QAW+1)'(QDEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_ptr_q];

endmodule

// ----- src/mmh_back.sv -----
// ----------------------------------------------------------------------------
// mmh_back: hash engine
// Sequencer that scrambles each word, folds it into the running hash and,
// on the last item, xors in the length, runs the final mix and emits the hash.
// ----------------------------------------------------------------------------
module mmh_back
	import mmh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] seed,
	input  logic        q_not_empty,
	input  entry_t      q_head,
	output logic        pop,
	mmh_out_if.source   hash_out
);

	back_state_t state_q;
	back_state_t state_d;

	logic [31:0] k_q;
	logic [31:0] h_q;
	logic [31:0] total_q;
	logic        in_msg_q;
	logic [2:0]  count_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] hash_q;
	logic        out_load;

	logic [31:0] h_base;
	logic [31:0] h_xor;
	logic [31:0] h_rot;
	logic [31:0] h_new;
	logic [31:0] len;
	logic [31:0] k_rot;

	// Fold of the scrambled key into the running hash.
	always_comb begin
		h_base = in_msg_q ? h_q : seed;
		h_xor  = h_base ^ k_q;
		h_rot  = {h_xor[18:0], h_xor[31:19]};
		h_new  = (count_q == FULL_COUNT) ? (h_rot + {h_rot[29:0], 2'b00} + ADD_N) : h_xor;
		len    = total_q + {29'd0, count_q};
		k_rot  = {k_q[16:0], k_q[31:17]};
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_not_empty) begin
					pop     = 1'b1;
					state_d = ST_SCRAMBLE;
				end
			end
			ST_SCRAMBLE: begin
				state_d = ST_FOLD;
			end
			ST_FOLD: begin
				state_d = last_q ? ST_FMIX1 : ST_IDLE;
			end
			ST_FMIX1: begin
				state_d = ST_FMIX2;
			end
			ST_FMIX2: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || hash_out.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Message tracking: length and whether the running hash is in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			in_msg_q <= 1'b0;
		end else if (state_q == ST_FOLD) begin
			if (last_q) begin
				total_q  <= '0;
				in_msg_q <= 1'b0;
			end else begin
				total_q  <= len;
				in_msg_q <= 1'b1;
			end
		end
	end

	// Datapath: one multiply per cycle, each result registered.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_not_empty) begin
					k_q     <= q_head.word * C1;
					count_q <= q_head.count;
					last_q  <= q_head.last;
				end
			end
			ST_SCRAMBLE: begin
				k_q <= k_rot * C2;
			end
			ST_FOLD: begin
				h_q <= last_q ? (h_new ^ len) : h_new;
			end
			ST_FMIX1: begin
				h_q <= (h_q ^ {16'd0, h_q[31:16]}) * FMIX1;
			end
			ST_FMIX2: begin
				h_q <= (h_q ^ {13'd0, h_q[31:13]}) * FMIX2;
			end
			default: begin
				h_q <= h_q;
			end
		endcase
	end

	// Output register: holds the hash until the sink takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (hash_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hash_q <= h_q ^ {16'd0, h_q[31:16]};
		end
	end

	assign hash_out.valid      = out_valid_q;
	assign hash_out.hash_value = hash_q;

endmodule

// ----- src/murmur3_32_hash_stream.sv -----
// ----------------------------------------------------------------------------
// murmur3_32_hash_stream: streaming MurmurHash3 x86_32
// Hashes a byte message that arrives as little-endian 32-bit words.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                              Transfer gives
//  msg_in    in   data_word, byte_count, is_last       one message word
//  hash_out  out  hash_value                           hash of one message
//  cfg       in   seed                                 new seed value
//
// A full word passes the back-end sequencer as key multiply, second key
// multiply and fold; a last item then adds two final-mix multiplies and an
// output load. The front classifies in the cycle of the transfer and a
// two-entry queue lets it keep taking words while the back end works.
// Reset clears the seed to zero and empties the queue; a held result keeps
// the back end in its output state until the sink takes it.
// ----------------------------------------------------------------------------
module murmur3_32_hash_stream
	import mmh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mmh_in_if.sink      msg_in,
	mmh_out_if.source   hash_out,
	mmh_cfg_if.sink     cfg
);

	logic        seed_write;
	logic [31:0] seed_q;
	logic        q_full;
	logic        q_not_empty;
	logic        push;
	logic        pop;
	entry_t      push_entry;
	entry_t      q_head;

	// Seed register, always ready for a transfer.
	assign cfg.ready  = 1'b1;
	assign seed_write = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_write) begin
			seed_q <= cfg.seed;
		end
	end

	// Front: classify incoming words.
	mmh_front u_front (
		.msg_in     (msg_in),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue between front and back.
	mmh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// Back: hash engine.
	mmh_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.hash_out    (hash_out)
	);

endmodule
